// ===== sv/gpdr_pkg.sv =====
// Package for the grace-period deferred-release block.
// Holds the word types, the controller/datapath command types and the codes.
// Depends on nothing.
package gpdr_pkg;

  localparam int CPU_W     = 3;
  localparam int MODE_W    = 3;
  localparam int KIND_W    = 2;
  localparam int HANDLE_W  = 32;
  localparam int SEQ_W     = 48;
  localparam int NEST_W    = 16;
  localparam int TICK_W    = 16;
  localparam int CPU_SLOTS = 8;

  localparam logic [MODE_W-1:0] MODE_LOCK   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UNLOCK = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CTX    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEFER  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SYNC   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TICK   = 3'd5;

  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BUSY  = 2'd3;

  localparam logic [SEQ_W-1:0]  SEQ_MAX       = {SEQ_W{1'b1}};
  localparam logic [NEST_W-1:0] NEST_MAX      = {NEST_W{1'b1}};
  localparam logic [TICK_W-1:0] TICK_MAX      = {TICK_W{1'b1}};
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd500;

  localparam logic ADDR_TIMEOUT = 1'b0;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [CPU_W-1:0]    cpu;
    logic [HANDLE_W-1:0] handle;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] released_handle;
    logic                last;
    logic                timed_out;
    logic                waiting;
    logic [SEQ_W-1:0]    current_seq;
    logic [SEQ_W-1:0]    completed_seq;
  } out_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit_ack;
    logic emit_rel;
    logic last;
    logic push_held;
  } dp_cmd_t;

  typedef struct packed {
    logic complete;
  } dp_status_t;

endpackage

// ===== sv/gpdr_queue.sv =====
// Storage for the deferred handles: one write port, one registered read port.
// Depends on nothing.
module gpdr_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] waddr,
  input  logic [31:0]                   wdata,
  input  logic [$clog2(QUEUE_DEPTH)-1:0] raddr,
  output logic [31:0]                   rdata
);

  logic [31:0] mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/gpdr_datapath.sv =====
// Datapath of the grace-period block: per-CPU nesting, sequence numbers,
// tick counter, held handle and result word. Uses gpdr_pkg.
module gpdr_datapath #(
  parameter int CPUS        = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  gpdr_pkg::in_t                    in_item,
  input  gpdr_pkg::dp_cmd_t                cmd,
  input  logic [gpdr_pkg::TICK_W-1:0]      timeout_ticks,
  output gpdr_pkg::dp_status_t             status,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
  output logic                             q_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   q_waddr,
  output logic [31:0]                      q_wdata,
  input  logic [31:0]                      q_rdata,
  output gpdr_pkg::out_t                   out_item
);

  localparam int NC     = (CPUS < gpdr_pkg::CPU_SLOTS) ? CPUS : gpdr_pkg::CPU_SLOTS;
  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic ALL_SLOTS = (CPUS <= gpdr_pkg::CPU_SLOTS);

  gpdr_pkg::in_t in_r;

  logic [gpdr_pkg::NEST_W-1:0]   nest_r [NC];
  logic [gpdr_pkg::NEST_W-1:0]   nest_nxt [NC];
  logic [NC-1:0]                 seen_r, seen_nxt;
  logic [gpdr_pkg::SEQ_W-1:0]    grace_r, grace_nxt;
  logic [gpdr_pkg::SEQ_W-1:0]    done_r, done_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic                          busy_r, busy_nxt;
  logic [gpdr_pkg::TICK_W-1:0]   elapsed_r, elapsed_nxt;
  logic                          held_v_r, held_v_nxt;
  logic [31:0]                   held_r, held_nxt;
  logic [gpdr_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic                          timed_r, timed_nxt;

  logic [NC-1:0]                 sel;
  logic [NC-1:0]                 zero_nxt;
  logic                          cpu_ok;
  logic                          start_gp;
  logic                          check;
  logic                          refuse;
  logic                          tick_to;
  logic                          passed;
  logic                          do_complete;
  logic [gpdr_pkg::TICK_W-1:0]   tick_inc;

  assign cpu_ok = int'(in_r.cpu) < CPUS;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      sel[i] = cpu_ok && (int'(in_r.cpu) == i);
    end
  end

  always_comb begin
    nest_nxt    = nest_r;
    seen_nxt    = seen_r;
    grace_nxt   = grace_r;
    done_nxt    = done_r;
    count_nxt   = count_r;
    busy_nxt    = busy_r;
    elapsed_nxt = elapsed_r;
    held_v_nxt  = held_v_r;
    held_nxt    = held_r;
    kind_nxt    = kind_r;
    timed_nxt   = timed_r;
    q_we        = 1'b0;
    q_waddr     = count_r[ADDR_W-1:0];
    q_wdata     = in_r.handle;
    start_gp    = 1'b0;
    check       = 1'b0;
    refuse      = 1'b0;
    tick_to     = 1'b0;
    do_complete = 1'b0;
    tick_inc    = (elapsed_r != gpdr_pkg::TICK_MAX) ?
                  elapsed_r + gpdr_pkg::TICK_W'(1) : elapsed_r;

    if (cmd.exec) begin
      case (in_r.mode)
        gpdr_pkg::MODE_LOCK: begin
          for (int i = 0; i < NC; i++) begin
            if (sel[i] && nest_r[i] != gpdr_pkg::NEST_MAX) begin
              nest_nxt[i] = nest_r[i] + gpdr_pkg::NEST_W'(1);
            end
          end
          check = 1'b1;
        end
        gpdr_pkg::MODE_UNLOCK: begin
          for (int i = 0; i < NC; i++) begin
            if (sel[i]) begin
              if (nest_r[i] != '0) begin
                nest_nxt[i] = nest_r[i] - gpdr_pkg::NEST_W'(1);
              end
              if (nest_r[i] <= gpdr_pkg::NEST_W'(1)) begin
                seen_nxt[i] = 1'b1;
              end
            end
          end
          check = 1'b1;
        end
        gpdr_pkg::MODE_CTX: begin
          for (int i = 0; i < NC; i++) begin
            if (sel[i] && nest_r[i] == '0) begin
              seen_nxt[i] = 1'b1;
            end
          end
          check = 1'b1;
        end
        gpdr_pkg::MODE_DEFER: begin
          if (busy_r) begin
            refuse = 1'b1;
          end else if (count_r == COUNT_FULL) begin
            held_nxt   = in_r.handle;
            held_v_nxt = 1'b1;
            start_gp   = 1'b1;
          end else begin
            q_we      = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        gpdr_pkg::MODE_SYNC: begin
          if (busy_r) begin
            refuse = 1'b1;
          end else begin
            start_gp = 1'b1;
          end
        end
        gpdr_pkg::MODE_TICK: begin
          if (busy_r) begin
            elapsed_nxt = tick_inc;
            check       = 1'b1;
            tick_to     = tick_inc >= timeout_ticks;
          end
        end
        default: begin
        end
      endcase

      // A new grace period invalidates every CPU's quiescent mark, unless the sequence number has saturated at SEQ_MAX.
      if (start_gp) begin
        if (grace_r != gpdr_pkg::SEQ_MAX) begin
          grace_nxt = grace_r + gpdr_pkg::SEQ_W'(1);
          seen_nxt  = '0;
        end
        elapsed_nxt = '0;
        busy_nxt    = 1'b1;
        check       = 1'b1;
      end
    end

    for (int i = 0; i < NC; i++) begin
      zero_nxt[i] = (nest_nxt[i] == '0);
    end
    passed = ALL_SLOTS && (&(zero_nxt & seen_nxt));

    if (cmd.exec) begin
      do_complete = check && busy_nxt && (passed || tick_to);
      if (do_complete) begin
        busy_nxt    = 1'b0;
        elapsed_nxt = '0;
        done_nxt    = grace_nxt;
        count_nxt   = '0;
        kind_nxt    = (count_r == '0) ? gpdr_pkg::KIND_EMPTY : gpdr_pkg::KIND_REL;
        timed_nxt   = !passed;
      end else begin
        kind_nxt  = refuse ? gpdr_pkg::KIND_BUSY : gpdr_pkg::KIND_ACK;
        timed_nxt = 1'b0;
      end
    end

    // The handle held back by a full queue goes in once the walk has emptied it.
    if (cmd.push_held && held_v_r) begin
      q_we       = 1'b1;
      q_waddr    = '0;
      q_wdata    = held_r;
      count_nxt  = CNT_W'(1);
      held_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NC; i++) begin
        nest_r[i] <= '0;
      end
      seen_r    <= '0;
      grace_r   <= gpdr_pkg::SEQ_W'(1);
      done_r    <= '0;
      count_r   <= '0;
      busy_r    <= 1'b0;
      elapsed_r <= '0;
      held_v_r  <= 1'b0;
      kind_r    <= gpdr_pkg::KIND_ACK;
      timed_r   <= 1'b0;
    end else begin
      nest_r    <= nest_nxt;
      seen_r    <= seen_nxt;
      grace_r   <= grace_nxt;
      done_r    <= done_nxt;
      count_r   <= count_nxt;
      busy_r    <= busy_nxt;
      elapsed_r <= elapsed_nxt;
      held_v_r  <= held_v_nxt;
      kind_r    <= kind_nxt;
      timed_r   <= timed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    if (cmd.load) begin
      in_r <= in_item;
    end
  end

  assign status.complete = do_complete;
  assign count           = count_r;

  always_comb begin
    out_item.kind            = cmd.emit_rel ? gpdr_pkg::KIND_REL : kind_r;
    out_item.released_handle = cmd.emit_rel ? q_rdata : '0;
    out_item.last            = cmd.last;
    out_item.timed_out       = timed_r;
    out_item.waiting         = busy_r;
    out_item.current_seq     = grace_r;
    out_item.completed_seq   = done_r;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_FULL)
    else $error("queue count beyond depth");

  a_idle_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> elapsed_r == '0)
    else $error("tick counter running outside a grace period");

  a_rel_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_rel |-> (!busy_r && done_r == grace_r))
    else $error("handle released before its grace period completed");
`endif

endmodule

// ===== sv/gpdr_ctrl.sv =====
// Controller of the grace-period block: command sequencing and the release walk.
// Uses gpdr_pkg.
module gpdr_ctrl #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  gpdr_pkg::dp_status_t             status,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] count,
  output gpdr_pkg::dp_cmd_t                cmd,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   raddr
);

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_ACK, S_WALK} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;

  always_comb begin
    cmd   = '0;
    raddr = ptr_r;
    case (state_r)
      S_IDLE: cmd.load = start;
      S_EXEC: begin
        cmd.exec = 1'b1;
        raddr    = '0;
      end
      S_ACK: begin
        cmd.emit_ack = 1'b1;
        cmd.last     = 1'b1;
      end
      S_WALK: begin
        cmd.emit_rel  = 1'b1;
        cmd.last      = (rem_r == CNT_W'(1));
        cmd.push_held = (rem_r == CNT_W'(1));
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    ptr_nxt   = ptr_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.complete && count != '0) begin
          rem_nxt   = count;
          ptr_nxt   = ADDR_W'(count - CNT_W'(1));
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_ACK;
        end
      end
      S_ACK: state_nxt = S_IDLE;
      S_WALK: begin
        rem_nxt = rem_r - CNT_W'(1);
        ptr_nxt = ptr_r - ADDR_W'(1);
        if (rem_r == CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rem_r   <= '0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

`ifndef SYNTHESIS
  a_walk_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> rem_r != '0)
    else $error("release walk with nothing left");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == S_EXEC)
    else $error("accepted word not executed");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_ack |=> !cmd.emit_ack && !cmd.emit_rel)
    else $error("acknowledge followed by a further result");
`endif

endmodule

// ===== sv/grace_period_deferred_release.sv =====
// Top level of the grace-period deferred-release block.
// Instantiates gpdr_ctrl, gpdr_datapath and gpdr_queue; uses gpdr_pkg.
//
// An input word (mode, cpu, handle) is taken at a clock edge with start high
// and busy low. Results leave on out_item with out_valid high for one cycle
// each; the receiver cannot hold them off, and out_item.last marks the final
// result of a word. The word is worked on in the cycle after acceptance and a
// single result is then on the ports in state S_ACK; busy falls at the edge
// that takes it, so no new word is taken before that result. A completing
// grace period releases every queued handle, one per cycle from the handle
// memory's registered read port (entry 0, then the last down to entry 1). A
// handle held back by a full queue is written into the emptied queue on the
// final release cycle. timeout_ticks is to be written over the APB port (byte
// address 0) only while idle, a rule for the user that the block itself does
// not enforce. Synchronous reset clears the nesting, sequence numbers, queue
// count and register to their start values; the handle memory is not cleared.
module grace_period_deferred_release #(
  parameter int CPUS        = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  gpdr_pkg::in_t  in_item,
  output logic           out_valid,
  output gpdr_pkg::out_t out_item,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  logic [gpdr_pkg::TICK_W-1:0] timeout_r;
  gpdr_pkg::dp_cmd_t           cmd;
  gpdr_pkg::dp_status_t        status;
  logic [CNT_W-1:0]            count;
  logic [ADDR_W-1:0]           raddr;
  logic [ADDR_W-1:0]           q_waddr;
  logic                        q_we;
  logic [31:0]                 q_wdata;
  logic [31:0]                 q_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= gpdr_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == gpdr_pkg::ADDR_TIMEOUT) begin
      timeout_r <= pwdata[gpdr_pkg::TICK_W-1:0];
    end
  end

  assign prdata = (paddr[2] == gpdr_pkg::ADDR_TIMEOUT) ?
                  {{(32 - gpdr_pkg::TICK_W){1'b0}}, timeout_r} : '0;

  gpdr_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .count  (count),
    .cmd    (cmd),
    .raddr  (raddr)
  );

  gpdr_datapath #(
    .CPUS        (CPUS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_item       (in_item),
    .cmd           (cmd),
    .timeout_ticks (timeout_r),
    .status        (status),
    .count         (count),
    .q_we          (q_we),
    .q_waddr       (q_waddr),
    .q_wdata       (q_wdata),
    .q_rdata       (q_rdata),
    .out_item      (out_item)
  );

  gpdr_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (raddr),
    .rdata (q_rdata)
  );

  assign out_valid = cmd.emit_ack | cmd.emit_rel;

endmodule

// ===== verif/grace_period_deferred_release_checker.sv =====
`timescale 1ns / 1ps
// Checker for the grace-period deferred-release block: watches the input, result and APB ports,
// keeps its own copy of the tracker state and compares every result word with its prediction.
// Depends on gpdr_pkg for the word types and codes.
module grace_period_deferred_release_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  gpdr_pkg::in_t  in_item,
  input  logic           out_valid,
  input  gpdr_pkg::out_t out_item,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  input  logic [31:0]    prdata,
  input  logic           pready,
  output int             results_due,
  output int             fails
);

  localparam int SLOTS = 64;

  logic [gpdr_pkg::TICK_W-1:0]   timeout_q;
  logic [gpdr_pkg::NEST_W-1:0]   depth [gpdr_pkg::CPU_SLOTS];
  logic [gpdr_pkg::SEQ_W-1:0]    seen [gpdr_pkg::CPU_SLOTS];
  logic [gpdr_pkg::SEQ_W-1:0]    grace_no;
  logic [gpdr_pkg::SEQ_W-1:0]    done_no;
  logic [gpdr_pkg::HANDLE_W-1:0] slot_handle [SLOTS];
  logic [gpdr_pkg::SEQ_W-1:0]    slot_tag [SLOTS];
  int                            slot_count;
  logic                          in_wait;
  logic [gpdr_pkg::TICK_W-1:0]   wait_ticks;
  logic                          held_v;
  logic [gpdr_pkg::HANDLE_W-1:0] held_h;
  gpdr_pkg::out_t                awaited [$];
  int                            due_count = 0;
  int                            miss_count = 0;

  assign results_due = due_count;
  assign fails       = miss_count;

  task automatic note_result(input logic [gpdr_pkg::KIND_W-1:0] k,
                             input logic [gpdr_pkg::HANDLE_W-1:0] h,
                             input logic timed, input logic fin);
    gpdr_pkg::out_t r;
    r.kind            = k;
    r.released_handle = h;
    r.last            = fin;
    r.timed_out       = timed;
    r.waiting         = in_wait;
    r.current_seq     = grace_no;
    r.completed_seq   = done_no;
    awaited.push_back(r);
  endtask

  function automatic logic readers_clear();
    for (int i = 0; i < gpdr_pkg::CPU_SLOTS; i++)
      if (depth[i] != 0 || seen[i] < grace_no) return 1'b0;
    return 1'b1;
  endfunction

  task automatic close_grace(input logic timed);
    logic [gpdr_pkg::HANDLE_W-1:0] freed [$];
    int i;
    in_wait    = 1'b0;
    wait_ticks = '0;
    done_no    = grace_no;
    i          = 0;
    while (i < slot_count) begin
      if (slot_tag[i] <= done_no) begin
        freed.push_back(slot_handle[i]);
        slot_count--;
        slot_handle[i] = slot_handle[slot_count];
        slot_tag[i]    = slot_tag[slot_count];
      end else begin
        i++;
      end
    end
    if (held_v && slot_count < SLOTS) begin
      slot_handle[slot_count] = held_h;
      slot_tag[slot_count]    = grace_no;
      slot_count++;
      held_v = 1'b0;
    end
    if (freed.size() == 0) begin
      note_result(gpdr_pkg::KIND_EMPTY, '0, timed, 1'b1);
    end else begin
      foreach (freed[k])
        note_result(gpdr_pkg::KIND_REL, freed[k], timed, k == freed.size() - 1);
    end
  endtask

  task automatic after_event();
    if (in_wait && readers_clear()) close_grace(1'b0);
    else note_result(gpdr_pkg::KIND_ACK, '0, 1'b0, 1'b1);
  endtask

  task automatic open_grace();
    if (grace_no < gpdr_pkg::SEQ_MAX) grace_no = grace_no + 1'b1;
    wait_ticks = '0;
    in_wait    = 1'b1;
    after_event();
  endtask

  task automatic step_tracker(input gpdr_pkg::in_t w);
    case (w.mode)
      gpdr_pkg::MODE_LOCK: begin
        if (depth[w.cpu] < gpdr_pkg::NEST_MAX) depth[w.cpu] = depth[w.cpu] + 1'b1;
        after_event();
      end
      gpdr_pkg::MODE_UNLOCK: begin
        if (depth[w.cpu] > 0) depth[w.cpu] = depth[w.cpu] - 1'b1;
        if (depth[w.cpu] == 0) seen[w.cpu] = grace_no;
        after_event();
      end
      gpdr_pkg::MODE_CTX: begin
        if (depth[w.cpu] == 0) seen[w.cpu] = grace_no;
        after_event();
      end
      gpdr_pkg::MODE_DEFER: begin
        if (in_wait) begin
          note_result(gpdr_pkg::KIND_BUSY, '0, 1'b0, 1'b1);
        end else if (slot_count >= SLOTS) begin
          held_h = w.handle;
          held_v = 1'b1;
          open_grace();
        end else begin
          slot_handle[slot_count] = w.handle;
          slot_tag[slot_count]    = grace_no;
          slot_count++;
          note_result(gpdr_pkg::KIND_ACK, '0, 1'b0, 1'b1);
        end
      end
      gpdr_pkg::MODE_SYNC: begin
        if (in_wait) note_result(gpdr_pkg::KIND_BUSY, '0, 1'b0, 1'b1);
        else open_grace();
      end
      gpdr_pkg::MODE_TICK: begin
        if (!in_wait) begin
          note_result(gpdr_pkg::KIND_ACK, '0, 1'b0, 1'b1);
        end else begin
          if (wait_ticks < gpdr_pkg::TICK_MAX) wait_ticks = wait_ticks + 1'b1;
          if (readers_clear()) close_grace(1'b0);
          else if (wait_ticks >= timeout_q) close_grace(1'b1);
          else note_result(gpdr_pkg::KIND_ACK, '0, 1'b0, 1'b1);
        end
      end
      default: note_result(gpdr_pkg::KIND_ACK, '0, 1'b0, 1'b1);
    endcase
  endtask

  task automatic check_result(input gpdr_pkg::out_t got);
    gpdr_pkg::out_t want;
    if (awaited.size() == 0) begin
      miss_count++;
      if (miss_count <= 10)
        $display("result word with none awaited: kind %0d handle %h last %b",
                 got.kind, got.released_handle, got.last);
    end else begin
      want = awaited.pop_front();
      if (got.kind !== want.kind || got.released_handle !== want.released_handle ||
          got.last !== want.last || got.timed_out !== want.timed_out ||
          got.waiting !== want.waiting || got.current_seq !== want.current_seq ||
          got.completed_seq !== want.completed_seq) begin
        miss_count++;
        if (miss_count <= 10) begin
          $display("result word mismatch at %0t", $realtime);
          $display("  expected kind %0d handle %h last %b timed_out %b waiting %b cur %h done %h",
                   want.kind, want.released_handle, want.last, want.timed_out, want.waiting,
                   want.current_seq, want.completed_seq);
          $display("  actual   kind %0d handle %h last %b timed_out %b waiting %b cur %h done %h",
                   got.kind, got.released_handle, got.last, got.timed_out, got.waiting,
                   got.current_seq, got.completed_seq);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      timeout_q  = gpdr_pkg::TIMEOUT_RESET;
      for (int i = 0; i < gpdr_pkg::CPU_SLOTS; i++) begin
        depth[i] = '0;
        seen[i]  = '0;
      end
      grace_no   = gpdr_pkg::SEQ_W'(1);
      done_no    = '0;
      slot_count = 0;
      in_wait    = 1'b0;
      wait_ticks = '0;
      held_v     = 1'b0;
      held_h     = '0;
      awaited.delete();
    end else begin
      if (psel && penable && pready && paddr == {gpdr_pkg::ADDR_TIMEOUT, 2'b00}) begin
        if (pwrite) begin
          timeout_q = pwdata[gpdr_pkg::TICK_W-1:0];
        end else if (prdata !== {16'h0000, timeout_q}) begin
          miss_count++;
          if (miss_count <= 10)
            $display("timeout register read: expected %h actual %h", timeout_q, prdata);
        end
      end
      if (out_valid) check_result(out_item);
      if (start && !busy) step_tracker(in_item);
    end
    due_count <= awaited.size();
  end

endmodule

// ===== verif/grace_period_deferred_release_tb.sv =====
`timescale 1ns / 1ps
// Top of the grace-period deferred-release testbench: clock, reset, APB set-up and input words.
// Instantiates grace_period_deferred_release and grace_period_deferred_release_checker.
module grace_period_deferred_release_tb;

  logic           clk     = 1'b0;
  logic           rst_n   = 1'b0;
  logic           start   = 1'b0;
  gpdr_pkg::in_t  in_item = '0;
  logic           psel    = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite  = 1'b0;
  logic [2:0]     paddr   = '0;
  logic [31:0]    pwdata  = '0;
  logic           busy;
  logic           out_valid;
  gpdr_pkg::out_t out_item;
  logic [31:0]    prdata;
  logic           pready;
  int             results_due;
  int             fails;

  int          lock_depth [gpdr_pkg::CPU_SLOTS];
  int          burst_left = 0;
  int          sent = 0;
  int          target;
  logic [15:0] phase_tmo [5];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  grace_period_deferred_release dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  grace_period_deferred_release_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .results_due(results_due), .fails(fails)
  );

  function automatic logic [31:0] pick_handle();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [2:0] m, input int c, input logic [31:0] h);
    gpdr_pkg::in_t w;
    w.mode   = m;
    w.cpu    = 3'(c);
    w.handle = h;
    if (burst_left == 0) begin
      start   <= 1'b0;
      in_item <= {3'($urandom), 3'($urandom), $urandom};
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    start   <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (m == gpdr_pkg::MODE_LOCK && lock_depth[c] < 65535) lock_depth[c]++;
    if (m == gpdr_pkg::MODE_UNLOCK && lock_depth[c] > 0) lock_depth[c]--;
  endtask

  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_due != 0 || busy) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {gpdr_pkg::ADDR_TIMEOUT, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic release_readers();
    int base;
    int c;
    base = $urandom_range(0, gpdr_pkg::CPU_SLOTS - 1);
    for (int k = 0; k < gpdr_pkg::CPU_SLOTS; k++) begin
      c = (base + k) % gpdr_pkg::CPU_SLOTS;
      while (lock_depth[c] > 0) send_word(gpdr_pkg::MODE_UNLOCK, c, $urandom);
      if ($urandom_range(0, 1)) send_word(gpdr_pkg::MODE_CTX, c, $urandom);
      else send_word(gpdr_pkg::MODE_UNLOCK, c, $urandom);
    end
  endtask

  task automatic grace_round();
    repeat ($urandom_range(0, 6))
      send_word(gpdr_pkg::MODE_DEFER, $urandom_range(0, 7), pick_handle());
    repeat ($urandom_range(0, 2))
      send_word(gpdr_pkg::MODE_LOCK, $urandom_range(0, 7), $urandom);
    send_word(gpdr_pkg::MODE_SYNC, $urandom_range(0, 7), $urandom);
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 2) == 0)
        send_word(gpdr_pkg::MODE_DEFER, $urandom_range(0, 7), pick_handle());
      else send_word(gpdr_pkg::MODE_TICK, $urandom_range(0, 7), $urandom);
    end
    release_readers();
  endtask

  task automatic random_round();
    logic [2:0] m;
    int         c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: grace_round();
      5, 6: repeat ($urandom_range(1, 6))
        send_word(gpdr_pkg::MODE_TICK, $urandom_range(0, 7), $urandom);
      7, 8: begin
        repeat ($urandom_range(1, 4)) begin
          m = 3'($urandom_range(0, 7));
          c = $urandom_range(0, 7);
          if (m == gpdr_pkg::MODE_LOCK && lock_depth[c] >= 4) m = gpdr_pkg::MODE_UNLOCK;
          send_word(m, c, pick_handle());
        end
      end
      default: begin
        send_word(gpdr_pkg::MODE_SYNC, $urandom_range(0, 7), $urandom);
        send_word(gpdr_pkg::MODE_DEFER, $urandom_range(0, 7), pick_handle());
        repeat ($urandom_range(1, 3))
          send_word(gpdr_pkg::MODE_CTX, $urandom_range(0, 7), $urandom);
      end
    endcase
  endtask

  initial begin
    foreach (lock_depth[i]) lock_depth[i] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_timeout(16'd3);
    send_word(gpdr_pkg::MODE_TICK, 0, 32'h0000_0000);
    send_word(gpdr_pkg::MODE_DEFER, 0, 32'h0000_0000);
    send_word(gpdr_pkg::MODE_DEFER, 7, 32'hFFFF_FFFF);
    send_word(gpdr_pkg::MODE_SYNC, 0, 32'h0000_0000);
    send_word(gpdr_pkg::MODE_DEFER, 1, 32'h1234_5678);
    send_word(gpdr_pkg::MODE_SYNC, 2, 32'h0000_0000);
    send_word(gpdr_pkg::MODE_LOCK, 7, 32'h0000_0000);
    send_word(gpdr_pkg::MODE_CTX, 7, 32'h0000_0000);
    repeat (3) send_word(gpdr_pkg::MODE_TICK, 4, 32'hFFFF_FFFF);
    send_word(3'd6, 5, 32'hFFFF_FFFF);
    send_word(3'd7, 2, 32'hA5A5_5A5A);
    send_word(gpdr_pkg::MODE_UNLOCK, 7, 32'h0000_0000);
    send_word(gpdr_pkg::MODE_UNLOCK, 0, 32'h0000_0000);
    send_word(gpdr_pkg::MODE_SYNC, 3, 32'h0000_0000);
    for (int k = 0; k < gpdr_pkg::CPU_SLOTS; k++) send_word(gpdr_pkg::MODE_CTX, k, $urandom);

    settle();
    set_timeout(16'hFFFF);
    repeat (70) send_word(gpdr_pkg::MODE_DEFER, $urandom_range(0, 7), pick_handle());
    release_readers();

    phase_tmo = '{16'h0000, 16'h0001, gpdr_pkg::TIMEOUT_RESET, 16'hFFFF, 16'h0000};
    phase_tmo[4] = 16'($urandom_range(2, 40));
    for (int p = 0; p < 5; p++) begin
      settle();
      set_timeout(phase_tmo[p]);
      target = sent + 15;
      while (sent < target) random_round();
      release_readers();
    end

    settle();
    repeat (8) @(posedge clk);
    if (fails == 0) $display("grace_period_deferred_release_tb OK");
    else $display("grace_period_deferred_release_tb NOT OK");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("grace_period_deferred_release_tb NOT OK");
    $finish;
  end

endmodule
